FILE: rtl/ldc_pkg.sv
// Shared types, codes and constants of the laser DAC command engine.
`default_nettype none
package ldc_pkg;

    localparam int DEF_BUFFER_POINTS = 2048;
    localparam int QUEUE_DEPTH       = 2;
    localparam logic [31:0] RESET_RATE = 32'd30000;

    localparam logic [1:0] REQ_COMMAND    = 2'd0;
    localparam logic [1:0] REQ_TICK       = 2'd1;
    localparam logic [1:0] REQ_DISCONNECT = 2'd2;

    localparam logic [7:0] OPCODE_PREPARE = 8'h70;
    localparam logic [7:0] OPCODE_START   = 8'h62;
    localparam logic [7:0] OPCODE_POINTS  = 8'h64;
    localparam logic [7:0] OPCODE_QRATE   = 8'h71;
    localparam logic [7:0] OPCODE_HALT    = 8'h73;
    localparam logic [7:0] OPCODE_QUERY   = 8'h3F;
    localparam logic [7:0] OPCODE_ESTOP_A = 8'h00;
    localparam logic [7:0] OPCODE_ESTOP_B = 8'hFF;
    localparam logic [7:0] OPCODE_CLEAR   = 8'h63;

    localparam logic [1:0] RK_ACK         = 2'd0;
    localparam logic [1:0] RK_NAK_FULL    = 2'd1;
    localparam logic [1:0] RK_NAK_INVALID = 2'd2;
    localparam logic [1:0] RK_DRAIN       = 2'd3;

    localparam logic [1:0] ENG_CODE_READY = 2'd0;
    localparam logic [1:0] ENG_CODE_ESTOP = 2'd3;
    localparam logic [1:0] PB_CODE_IDLE     = 2'd0;
    localparam logic [1:0] PB_CODE_PREPARED = 2'd1;
    localparam logic [1:0] PB_CODE_PLAYING  = 2'd2;

    typedef enum logic [3:0] {
        OPC_PREPARE,
        OPC_BEGIN,
        OPC_DATA_OK,
        OPC_DATA_BAD,
        OPC_QRATE,
        OPC_STOP,
        OPC_PING,
        OPC_ESTOP,
        OPC_CLEAR,
        OPC_UNKNOWN,
        OPC_TICK,
        OPC_DISCONNECT
    } opclass_t;

    typedef enum logic [1:0] {
        ENG_READY = 2'b01,
        ENG_ESTOP = 2'b10
    } eng_state_t;

    typedef enum logic [2:0] {
        PB_IDLE     = 3'b001,
        PB_PREPARED = 3'b010,
        PB_PLAYING  = 3'b100
    } pb_state_t;

    typedef struct packed {
        opclass_t    op;
        logic [7:0]  code;
        logic [31:0] rate;
        logic [15:0] points;
        logic        timed_out;
    } entry_t;

endpackage
`default_nettype wire

FILE: rtl/ldc_front.sv
// Front end: request handshake and classification of each request.
`default_nettype none
module ldc_front
    import ldc_pkg::*;
#(
    parameter int BUFFER_POINTS = DEF_BUFFER_POINTS
)
(
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  command_code,
    input  wire logic [31:0] rate_arg,
    input  wire logic [15:0] points_arg,
    input  wire logic        timed_out,
    input  wire logic        q_full,
    output logic             q_push,
    output entry_t           q_entry
);

    localparam logic [16:0] MAX_POINTS = 17'(BUFFER_POINTS);

    logic     data_ok;
    logic     keep;
    opclass_t op;

    assign data_ok = (points_arg != 16'd0) && ({1'b0, points_arg} <= MAX_POINTS);

    always_comb
    begin
        op   = OPC_PING;
        keep = 1'b1;
        unique case (req_type)
            REQ_COMMAND:
            begin
                unique case (command_code)
                    OPCODE_PREPARE: op = OPC_PREPARE;
                    OPCODE_START:   op = OPC_BEGIN;
                    OPCODE_POINTS:  op = data_ok ? OPC_DATA_OK : OPC_DATA_BAD;
                    OPCODE_QRATE:   op = OPC_QRATE;
                    OPCODE_HALT:    op = OPC_STOP;
                    OPCODE_QUERY:   op = OPC_PING;
                    OPCODE_ESTOP_A: op = OPC_ESTOP;
                    OPCODE_ESTOP_B: op = OPC_ESTOP;
                    OPCODE_CLEAR:   op = OPC_CLEAR;
                    default:        op = OPC_UNKNOWN;
                endcase
            end
            REQ_TICK:       op = OPC_TICK;
            REQ_DISCONNECT: op = OPC_DISCONNECT;
            default:        keep = 1'b0;
        endcase
    end

    assign req_stall         = q_full;
    assign q_push            = req_valid && !q_full && keep;
    assign q_entry.op        = op;
    assign q_entry.code      = command_code;
    assign q_entry.rate      = rate_arg;
    assign q_entry.points    = points_arg;
    assign q_entry.timed_out = timed_out;

endmodule
`default_nettype wire

FILE: rtl/ldc_queue.sv
// Short request queue between the front end and the execution back end.
`default_nettype none
module ldc_queue
    import ldc_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  wire entry_t push_entry,
    output logic        full,
    output logic        head_valid,
    output entry_t      head,
    input  wire logic   pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST    = PTR_W'(QUEUE_DEPTH - 1);

    entry_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/ldc_back.sv
// Back end: engine, playback, buffer, rate and count state plus the response register.
`default_nettype none
module ldc_back
    import ldc_pkg::*;
#(
    parameter int BUFFER_POINTS = DEF_BUFFER_POINTS
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   head_valid,
    input  wire entry_t head,
    output logic        pop,
    output logic        rsp_valid,
    input  wire logic   rsp_stall,
    output logic [1:0]  response_kind,
    output logic [7:0]  command_echo,
    output logic [1:0]  engine_state,
    output logic        estop_flag,
    output logic [1:0]  play_status,
    output logic [11:0] buffer_level,
    output logic [31:0] current_rate,
    output logic [31:0] played_count,
    output logic [11:0] drained_points
);

    localparam int FILL_W = $clog2(BUFFER_POINTS + 1);

    eng_state_t        eng_reg, eng_next;
    pb_state_t         pb_reg, pb_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [31:0]       rate_reg, rate_next;
    logic [31:0]       count_reg, count_next;
    logic [FILL_W-1:0] drained;
    logic [1:0]        kind;
    logic              has_rsp;
    logic              can_load;
    logic              load;
    logic              rsp_valid_reg;
    logic [FILL_W+11:0] fill_wide;
    logic [FILL_W+11:0] drain_wide;

    logic [1:0]  kind_reg;
    logic [7:0]  echo_reg;
    logic [1:0]  eng_out_reg;
    logic        estop_out_reg;
    logic [1:0]  pb_out_reg;
    logic [11:0] fill_out_reg;
    logic [31:0] rate_out_reg;
    logic [31:0] count_out_reg;
    logic [11:0] drain_out_reg;

    assign has_rsp  = (head.op != OPC_DISCONNECT);
    assign can_load = !rsp_valid_reg || !rsp_stall;
    assign pop      = head_valid && (!has_rsp || can_load);
    assign load     = pop && has_rsp;

    always_comb
    begin
        eng_next   = eng_reg;
        pb_next    = pb_reg;
        fill_next  = fill_reg;
        rate_next  = rate_reg;
        count_next = count_reg;
        drained    = '0;
        kind       = RK_ACK;
        unique case (head.op)
            OPC_PREPARE:
            begin
                if (eng_reg == ENG_READY && pb_reg == PB_IDLE)
                begin
                    fill_next  = '0;
                    pb_next    = PB_PREPARED;
                    count_next = '0;
                end
                else
                begin
                    kind = RK_NAK_INVALID;
                end
            end
            OPC_BEGIN:
            begin
                if (pb_reg == PB_PREPARED)
                begin
                    rate_next  = head.rate;
                    count_next = '0;
                    pb_next    = PB_PLAYING;
                end
                else
                begin
                    kind = RK_NAK_INVALID;
                end
            end
            OPC_DATA_OK:
            begin
                if (pb_reg != PB_IDLE)
                begin
                    fill_next = head.points[FILL_W-1:0];
                end
                else
                begin
                    kind = RK_NAK_INVALID;
                end
            end
            OPC_DATA_BAD:
            begin
                kind = RK_NAK_INVALID;
            end
            OPC_QRATE:
            begin
                if (pb_reg != PB_IDLE)
                begin
                    rate_next = head.rate;
                end
                else
                begin
                    kind = RK_NAK_INVALID;
                end
            end
            OPC_STOP:
            begin
                pb_next   = PB_IDLE;
                fill_next = '0;
            end
            OPC_PING:
            begin
            end
            OPC_ESTOP:
            begin
                eng_next  = ENG_ESTOP;
                pb_next   = PB_IDLE;
                fill_next = '0;
            end
            OPC_CLEAR:
            begin
                if (eng_reg == ENG_ESTOP)
                begin
                    eng_next = ENG_READY;
                end
                else
                begin
                    kind = RK_NAK_INVALID;
                end
            end
            OPC_UNKNOWN:
            begin
                eng_next = ENG_ESTOP;
                pb_next  = PB_IDLE;
            end
            OPC_TICK:
            begin
                kind      = RK_DRAIN;
                drained   = (head.timed_out && pb_reg == PB_PLAYING) ? '0 : fill_reg;
                fill_next = '0;
                if (pb_reg == PB_PLAYING)
                begin
                    count_next = count_reg + {{(32-FILL_W){1'b0}}, drained};
                end
            end
            OPC_DISCONNECT:
            begin
                pb_next = PB_IDLE;
            end
            default:
            begin
            end
        endcase
    end

    assign fill_wide  = {12'd0, fill_next};
    assign drain_wide = {12'd0, drained};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eng_reg       <= ENG_READY;
            pb_reg        <= PB_IDLE;
            fill_reg      <= '0;
            rate_reg      <= RESET_RATE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                eng_reg   <= eng_next;
                pb_reg    <= pb_next;
                fill_reg  <= fill_next;
                rate_reg  <= rate_next;
                count_reg <= count_next;
            end
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg      <= kind;
            echo_reg      <= (head.op == OPC_TICK) ? 8'd0 : head.code;
            eng_out_reg   <= (eng_next == ENG_ESTOP) ? ENG_CODE_ESTOP : ENG_CODE_READY;
            estop_out_reg <= (eng_next == ENG_ESTOP);
            unique case (pb_next)
                PB_IDLE:     pb_out_reg <= PB_CODE_IDLE;
                PB_PREPARED: pb_out_reg <= PB_CODE_PREPARED;
                PB_PLAYING:  pb_out_reg <= PB_CODE_PLAYING;
                default:     pb_out_reg <= PB_CODE_IDLE;
            endcase
            fill_out_reg  <= fill_wide[11:0];
            rate_out_reg  <= rate_next;
            count_out_reg <= count_next;
            drain_out_reg <= drain_wide[11:0];
        end
    end

    assign rsp_valid      = rsp_valid_reg;
    assign response_kind  = kind_reg;
    assign command_echo   = echo_reg;
    assign engine_state   = eng_out_reg;
    assign estop_flag     = estop_out_reg;
    assign play_status    = pb_out_reg;
    assign buffer_level   = fill_out_reg;
    assign current_rate   = rate_out_reg;
    assign played_count   = count_out_reg;
    assign drained_points = drain_out_reg;

endmodule
`default_nettype wire

FILE: rtl/laser_dac_command_state_machine_core.sv
// A response passes through the queue entry and then the response register.
// Throughput: one request per cycle unless rsp_stall holds the response register.
// The two-entry queue holds requests while the response register is stalled.
// Disconnect and unused request types produce no response.
// Reset (rst_n low, asynchronous): ready, idle, empty buffer, rate 30000, count 0, queue empty.
`default_nettype none
module laser_dac_command_state_machine_core
    import ldc_pkg::*;
#(
    parameter int BUFFER_POINTS = DEF_BUFFER_POINTS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic [1:0]  req_type,
    input  wire logic [7:0]  command_code,
    input  wire logic [31:0] rate_arg,
    input  wire logic [15:0] points_arg,
    input  wire logic        timed_out,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [1:0]       response_kind,
    output logic [7:0]       command_echo,
    output logic [1:0]       engine_state,
    output logic             estop_flag,
    output logic [1:0]       play_status,
    output logic [11:0]      buffer_level,
    output logic [31:0]      current_rate,
    output logic [31:0]      played_count,
    output logic [11:0]      drained_points
);

    logic   q_full;
    logic   q_push;
    entry_t q_entry;
    logic   head_valid;
    entry_t head;
    logic   pop;

    ldc_front #(
        .BUFFER_POINTS(BUFFER_POINTS)
    ) u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .command_code(command_code),
        .rate_arg    (rate_arg),
        .points_arg  (points_arg),
        .timed_out   (timed_out),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    ldc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_entry(q_entry),
        .full      (q_full),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop)
    );

    ldc_back #(
        .BUFFER_POINTS(BUFFER_POINTS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .response_kind (response_kind),
        .command_echo  (command_echo),
        .engine_state  (engine_state),
        .estop_flag    (estop_flag),
        .play_status   (play_status),
        .buffer_level  (buffer_level),
        .current_rate  (current_rate),
        .played_count  (played_count),
        .drained_points(drained_points)
    );

endmodule
`default_nettype wire

FILE: dv/laser_dac_command_state_machine_core_test.sv
// Self-checking testbench for the laser DAC command engine core.
`default_nettype none
module laser_dac_command_state_machine_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ldc_pkg::*;

    localparam logic [1:0] REQ_UNUSED     = 2'd3;
    localparam logic [7:0] OPCODE_UNKNOWN = 8'h41;
    localparam int         CYCLE_LIMIT    = 400000;
    localparam int         RANDOM_ITEMS   = 450;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  echo;
        logic [1:0]  engine;
        logic        estop;
        logic [1:0]  playback;
        logic [11:0] fullness;
        logic [31:0] rate;
        logic [31:0] played;
        logic [11:0] drained;
    } status_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  req_type;
    logic [7:0]  command_code;
    logic [31:0] rate_arg;
    logic [15:0] points_arg;
    logic        timed_out;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    logic [1:0]  response_kind;
    logic [7:0]  command_echo;
    logic [1:0]  engine_state;
    logic        estop_flag;
    logic [1:0]  play_status;
    logic [11:0] buffer_level;
    logic [31:0] current_rate;
    logic [31:0] played_count;
    logic [11:0] drained_points;

    logic [1:0]  engine_q;
    logic [1:0]  playback_q;
    logic [11:0] fill_q;
    logic [31:0] rate_q;
    logic [31:0] played_q;

    status_t pending_status[$];
    status_t oldest_status;
    int      errors      = 0;
    int      items_sent  = 0;
    int      cycle_count = 0;
    int      burst_left  = 0;
    int      stall_run   = 0;
    int      stall_pct   = 0;
    bit      gaps_on     = 1'b0;

    laser_dac_command_state_machine_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .req_type       (req_type),
        .command_code   (command_code),
        .rate_arg       (rate_arg),
        .points_arg     (points_arg),
        .timed_out      (timed_out),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .response_kind  (response_kind),
        .command_echo   (command_echo),
        .engine_state   (engine_state),
        .estop_flag     (estop_flag),
        .play_status    (play_status),
        .buffer_level   (buffer_level),
        .current_rate   (current_rate),
        .played_count   (played_count),
        .drained_points (drained_points)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("laser_dac_command_state_machine_core_test: done, errors");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (stall_run > 0)
        begin
            stall_run--;
            rsp_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_run = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
        end
        else
        begin
            rsp_stall <= 1'b0;
        end
    end

    function automatic void reset_dac_model();
        engine_q   = ENG_CODE_READY;
        playback_q = PB_CODE_IDLE;
        fill_q     = '0;
        rate_q     = RESET_RATE;
        played_q   = '0;
    endfunction

    function automatic void push_status(logic [1:0] kind, logic [7:0] echo,
                                        logic [11:0] drained);
        status_t s;
        s.kind     = kind;
        s.echo     = echo;
        s.engine   = engine_q;
        s.estop    = (engine_q == ENG_CODE_ESTOP);
        s.playback = playback_q;
        s.fullness = fill_q;
        s.rate     = rate_q;
        s.played   = played_q;
        s.drained  = drained;
        pending_status.push_back(s);
    endfunction

    function automatic void update_dac_model(logic [1:0] rtype, logic [7:0] code,
                                             logic [31:0] rate, logic [15:0] pts,
                                             logic tout);
        logic [1:0]  kind;
        logic [11:0] drained;
        bit          active;
        active = (playback_q == PB_CODE_PREPARED) || (playback_q == PB_CODE_PLAYING);
        kind   = RK_ACK;
        case (rtype)
            REQ_COMMAND:
            begin
                case (code)
                    OPCODE_PREPARE:
                        if (engine_q == ENG_CODE_READY && playback_q == PB_CODE_IDLE)
                        begin
                            fill_q     = '0;
                            playback_q = PB_CODE_PREPARED;
                            played_q   = '0;
                        end
                        else
                            kind = RK_NAK_INVALID;
                    OPCODE_START:
                        if (playback_q == PB_CODE_PREPARED)
                        begin
                            rate_q     = rate;
                            played_q   = '0;
                            playback_q = PB_CODE_PLAYING;
                        end
                        else
                            kind = RK_NAK_INVALID;
                    OPCODE_POINTS:
                        if (pts == 0 || pts > DEF_BUFFER_POINTS || !active)
                            kind = RK_NAK_INVALID;
                        else
                            fill_q = pts[11:0];
                    OPCODE_QRATE:
                        if (active)
                            rate_q = rate;
                        else
                            kind = RK_NAK_INVALID;
                    OPCODE_HALT:
                    begin
                        playback_q = PB_CODE_IDLE;
                        fill_q     = '0;
                    end
                    OPCODE_QUERY: ;
                    OPCODE_ESTOP_A, OPCODE_ESTOP_B:
                    begin
                        engine_q   = ENG_CODE_ESTOP;
                        playback_q = PB_CODE_IDLE;
                        fill_q     = '0;
                    end
                    OPCODE_CLEAR:
                        if (engine_q == ENG_CODE_ESTOP)
                            engine_q = ENG_CODE_READY;
                        else
                            kind = RK_NAK_INVALID;
                    default:
                    begin
                        engine_q   = ENG_CODE_ESTOP;
                        playback_q = PB_CODE_IDLE;
                    end
                endcase
                push_status(kind, code, '0);
            end
            REQ_TICK:
            begin
                if (tout && playback_q == PB_CODE_PLAYING)
                    fill_q = '0;
                drained = fill_q;
                fill_q  = '0;
                if (drained != 0 && playback_q == PB_CODE_PLAYING)
                    played_q = played_q + 32'(drained);
                push_status(RK_DRAIN, '0, drained);
            end
            REQ_DISCONNECT:
                playback_q = PB_CODE_IDLE;
            default: ;
        endcase
    endfunction

    task automatic report_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (pending_status.size() == 0)
            begin
                errors++;
                $display("%0t: expected no response, actual kind %0h echo %0h",
                         $time, response_kind, command_echo);
            end
            else
            begin
                oldest_status = pending_status.pop_front();
                report_field("response_kind", 32'(oldest_status.kind), 32'(response_kind));
                report_field("command_echo", 32'(oldest_status.echo), 32'(command_echo));
                report_field("engine_state", 32'(oldest_status.engine), 32'(engine_state));
                report_field("estop_flag", 32'(oldest_status.estop), 32'(estop_flag));
                report_field("play_status", 32'(oldest_status.playback), 32'(play_status));
                report_field("buffer_level", 32'(oldest_status.fullness), 32'(buffer_level));
                report_field("current_rate", oldest_status.rate, current_rate);
                report_field("played_count", oldest_status.played, played_count);
                report_field("drained_points", 32'(oldest_status.drained),
                             32'(drained_points));
            end
        end
    end

    // enter and leave at a falling edge
    task automatic issue_request(input logic [1:0] rtype, input logic [7:0] code,
                                 input logic [31:0] rate, input logic [15:0] pts,
                                 input logic tout);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                req_valid    <= 1'b0;
                req_type     <= 2'($urandom);
                command_code <= 8'($urandom);
                rate_arg     <= $urandom;
                points_arg   <= 16'($urandom);
                timed_out    <= 1'($urandom);
                repeat ($urandom_range(1, 6)) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
            burst_left--;
        end
        req_valid    <= 1'b1;
        req_type     <= rtype;
        command_code <= code;
        rate_arg     <= rate;
        points_arg   <= pts;
        timed_out    <= tout;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        update_dac_model(rtype, code, rate, pts, tout);
        if (rtype != REQ_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic send_cmd(input logic [7:0] code, input logic [31:0] rate,
                            input logic [15:0] pts);
        issue_request(REQ_COMMAND, code, rate, pts, 1'($urandom_range(0, 1)));
    endtask

    task automatic send_tick(input logic tout);
        issue_request(REQ_TICK, 8'($urandom), $urandom, 16'($urandom), tout);
    endtask

    task automatic wait_for_results();
        req_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    function automatic logic [31:0] pick_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom_range(1000, 100000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] pick_points();
        case ($urandom_range(0, 9))
            6:       return 16'(DEF_BUFFER_POINTS);
            7:       return '0;
            8:       return 16'($urandom_range(DEF_BUFFER_POINTS + 1, 65535));
            9:       return 16'($urandom);
            default: return 16'($urandom_range(1, DEF_BUFFER_POINTS));
        endcase
    endfunction

    task automatic send_active_traffic();
        logic [7:0] misc [4];
        misc = '{OPCODE_QUERY, OPCODE_PREPARE, OPCODE_START, OPCODE_CLEAR};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: send_cmd(OPCODE_POINTS, $urandom, pick_points());
            5, 6, 7:       send_tick($urandom_range(0, 4) == 0);
            8:             send_cmd(OPCODE_QRATE, pick_rate(), 16'($urandom));
            default:       send_cmd(misc[2'($urandom_range(0, 3))], pick_rate(), pick_points());
        endcase
    endtask

    task automatic send_session();
        logic [7:0] enders [5];
        enders = '{OPCODE_HALT, OPCODE_ESTOP_A, OPCODE_ESTOP_B, OPCODE_QUERY, OPCODE_UNKNOWN};
        if (engine_q == ENG_CODE_ESTOP || $urandom_range(0, 7) == 0)
            send_cmd(OPCODE_CLEAR, $urandom, 16'($urandom));
        send_cmd(OPCODE_PREPARE, $urandom, 16'($urandom));
        repeat ($urandom_range(0, 3)) send_active_traffic();
        if ($urandom_range(0, 9) != 0)
            send_cmd(OPCODE_START, pick_rate(), 16'($urandom));
        repeat ($urandom_range(1, 12)) send_active_traffic();
        case ($urandom_range(0, 3))
            0:       issue_request(REQ_DISCONNECT, 8'($urandom), $urandom, 16'($urandom),
                                   1'($urandom));
            1:       ;
            default: send_cmd(enders[3'($urandom_range(0, 4))], $urandom, 16'($urandom));
        endcase
    endtask

    task automatic send_noise();
        issue_request(2'($urandom), 8'($urandom), $urandom, 16'($urandom), 1'($urandom));
    endtask

    task automatic test_reset_status();
        send_cmd(OPCODE_QUERY, '0, '0);
    endtask

    task automatic test_idle_refusals();
        send_cmd(OPCODE_START, 32'd12345, '0);
        send_cmd(OPCODE_POINTS, '0, 16'd5);
        send_cmd(OPCODE_QRATE, 32'd5000, '0);
        send_cmd(OPCODE_CLEAR, '0, '0);
    endtask

    task automatic test_playback();
        send_cmd(OPCODE_PREPARE, '0, '0);
        send_cmd(OPCODE_POINTS, '1, 16'd0);
        send_cmd(OPCODE_POINTS, '0, 16'(DEF_BUFFER_POINTS));
        send_cmd(OPCODE_POINTS, '0, 16'hFFFF);
        send_cmd(OPCODE_QRATE, 32'hFFFF_FFFF, '0);
        send_cmd(OPCODE_START, '0, '1);
        send_cmd(OPCODE_POINTS, '0, 16'd1);
        send_tick(1'b0);
        send_cmd(OPCODE_POINTS, '0, 16'(DEF_BUFFER_POINTS));
        send_tick(1'b1);
        send_cmd(OPCODE_PREPARE, '0, '0);
        issue_request(REQ_DISCONNECT, '0, '0, '0, 1'b0);
        send_tick(1'b0);
    endtask

    task automatic test_estop_paths();
        send_cmd(OPCODE_ESTOP_A, '0, '0);
        send_cmd(OPCODE_PREPARE, '0, '0);
        send_cmd(OPCODE_CLEAR, '0, '0);
        send_cmd(OPCODE_PREPARE, '0, '0);
        send_cmd(OPCODE_POINTS, '0, 16'd100);
        send_cmd(OPCODE_UNKNOWN, '0, '0);
        send_tick(1'b1);
        send_cmd(OPCODE_ESTOP_B, '0, '0);
        send_cmd(OPCODE_CLEAR, '0, '0);
        issue_request(REQ_UNUSED, '1, '1, '1, 1'b1);
    endtask

    task automatic test_random_traffic();
        int phase_end;
        for (int phase = 0; phase < 4; phase++)
        begin
            gaps_on   = (phase == 1 || phase == 2);
            stall_pct = (phase == 0) ? 0 : (phase == 2) ? 60 : 25;
            phase_end = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    send_session();
            end
            wait_for_results();
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req_type     = '0;
        command_code = '0;
        rate_arg     = '0;
        points_arg   = '0;
        timed_out    = 1'b0;
        reset_dac_model();
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_status();
        test_idle_refusals();
        test_playback();
        test_estop_paths();
        wait_for_results();
        test_random_traffic();

        req_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("laser_dac_command_state_machine_core_test: done, clean");
        else
            $display("laser_dac_command_state_machine_core_test: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

FILE: sim.f
rtl/ldc_pkg.sv
rtl/ldc_front.sv
rtl/ldc_queue.sv
rtl/ldc_back.sv
rtl/laser_dac_command_state_machine_core.sv
dv/laser_dac_command_state_machine_core_test.sv
